// ===== hdl/magma_pkg.sv =====
`default_nettype none
package magma_pkg;

	localparam int WORD_W = 32;
	localparam int KEY_W  = 64;
	localparam int CFG_IDX_W = 3;
	localparam int ROT_LEFT  = 11;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [3:0] nibble_t;
	typedef nibble_t sbox_row_t [16];
	typedef sbox_row_t sbox_tab_t [8];

	localparam sbox_tab_t SBOX = '{
		'{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
		  4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2},
		'{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
		  4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
		'{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
		  4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
		'{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
		  4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
		'{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
		  4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
		'{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
		'{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
		  4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
		'{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
		  4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1}
	};

	// Key number (0..7) used by encryption round r.
	function automatic logic [2:0] enc_key_idx(input int r, input int rounds);
		logic [2:0] low;
		low = 3'(r);
		if (r < rounds - 8)
			return low;
		return 3'd7 - low;
	endfunction

	function automatic word_t round_fn(input word_t half, input word_t k);
		word_t sum;
		word_t sub;
		sum = half + k;
		for (int i = 0; i < 8; i++) begin
			sub[(7-i)*4 +: 4] = SBOX[i][sum[(7-i)*4 +: 4]];
		end
		return {sub[WORD_W-1-ROT_LEFT:0], sub[WORD_W-1 -: ROT_LEFT]};
	endfunction

endpackage
`default_nettype wire

// ===== hdl/magma_stage.sv =====
`default_nettype none
module magma_stage #(
	parameter bit LAST_ROUND = 1'b0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic             in_vld,
	input  wire magma_pkg::word_t in_hi,
	input  wire magma_pkg::word_t in_lo,
	input  wire magma_pkg::word_t rkey,
	output logic                  out_vld,
	output magma_pkg::word_t      out_hi,
	output magma_pkg::word_t      out_lo
);
	import magma_pkg::*;

	logic  vld_s1;
	word_t hi_s1;
	word_t lo_s1;
	word_t mixed;

	assign mixed = round_fn(in_lo, rkey) ^ in_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_vld) begin
			if (LAST_ROUND) begin
				hi_s1 <= mixed;
				lo_s1 <= in_lo;
			end else begin
				hi_s1 <= in_lo;
				lo_s1 <= mixed;
			end
		end
	end

	assign out_vld = vld_s1;
	assign out_hi  = hi_s1;
	assign out_lo  = lo_s1;
endmodule
`default_nettype wire

// ===== hdl/magma_block_cipher_unit.sv =====
`default_nettype none
// Magma 64-bit block cipher, one round per pipeline stage.
// Throughput: one item per cycle while out_stall is low; each stage holds one item and bubbles collapse.
// Reset: pipeline empty, key words zero, direction encrypt.
module magma_block_cipher_unit #(
	parameter int ROUNDS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [magma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [magma_pkg::KEY_W-1:0]  cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire magma_pkg::word_t             block_hi,
	input  wire magma_pkg::word_t             block_lo,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output magma_pkg::word_t                  out_hi,
	output magma_pkg::word_t                  out_lo
);
	import magma_pkg::*;

	logic [KEY_W-1:0] key_word_q [4];
	logic             direction_q;

	logic  vld [ROUNDS+1];
	word_t hi  [ROUNDS+1];
	word_t lo  [ROUNDS+1];
	logic  adv [ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_word_q[0] <= '0;
			key_word_q[1] <= '0;
			key_word_q[2] <= '0;
			key_word_q[3] <= '0;
			direction_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_WORD0: key_word_q[0] <= cfg_data;
				REG_KEY_WORD1: key_word_q[1] <= cfg_data;
				REG_KEY_WORD2: key_word_q[2] <= cfg_data;
				REG_KEY_WORD3: key_word_q[3] <= cfg_data;
				REG_DIRECTION: direction_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign vld[0] = in_valid;
	assign hi[0]  = block_hi;
	assign lo[0]  = block_lo;
	assign adv[ROUNDS] = !out_stall;
	assign in_stall = !adv[0];

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		localparam logic [2:0] ENC_SEL = enc_key_idx(r, ROUNDS);
		localparam logic [2:0] DEC_SEL = enc_key_idx(ROUNDS - 1 - r, ROUNDS);
		logic [2:0]       sel;
		logic [KEY_W-1:0] kw;
		word_t            rkey;

		assign sel  = direction_q ? ENC_SEL : DEC_SEL;
		assign kw   = key_word_q[sel[2:1]];
		assign rkey = sel[0] ? kw[WORD_W-1:0] : kw[KEY_W-1:WORD_W];
		// stage r+1 takes a new item when empty or when it hands its item on
		assign adv[r] = !vld[r+1] || adv[r+1];

		magma_stage #(
			.LAST_ROUND(r == ROUNDS - 1)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (adv[r]),
			.in_vld (vld[r]),
			.in_hi  (hi[r]),
			.in_lo  (lo[r]),
			.rkey   (rkey),
			.out_vld(vld[r+1]),
			.out_hi (hi[r+1]),
			.out_lo (lo[r+1])
		);
	end

	assign out_valid = vld[ROUNDS];
	assign out_hi    = hi[ROUNDS];
	assign out_lo    = lo[ROUNDS];
endmodule
`default_nettype wire
